// ===== design/lut3d_trilinear_color_map_defines.svh =====
// assertion helpers shared by the checker
`ifndef LUT3D_TRILINEAR_COLOR_MAP_DEFINES_SVH
`define LUT3D_TRILINEAR_COLOR_MAP_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define LUT3D_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lut3d check failed");

// condition must hold at the following clock edge
`define LUT3D_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lut3d check failed");

`endif

// ===== design/lut3d_pkg.sv =====
package lut3d_pkg;

    // default lattice points per axis
    localparam int MAX_CUBE_SIZE_DEF = 33;

    // field widths
    localparam int CFG_W   = 6;
    localparam int IDX_W   = 16;
    localparam int ENTRY_W = 16;
    localparam int PIX_W   = 8;

    // cube size after reset
    localparam int CUBE_RESET = 33;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // output scaling: denominator is 65025 * 4096
    localparam longint DEN      = 64'd266342400;
    localparam longint DEN_HALF = 64'd133171200;
    localparam longint DEN_TOP  = 64'd68183654400;
    localparam int     W_FULL   = 65025;
    localparam int     W_MAX    = 255;
    // floor(2^32 / 65025)
    localparam int     RECIP_FULL = 66051;
    // floor(2^16 / 255)
    localparam int     RECIP_255  = 257;

endpackage

// ===== design/lut3d_in_if.sv =====
interface lut3d_in_if;
    import lut3d_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [IDX_W-1:0]           entry_index;
    logic signed [ENTRY_W-1:0]  entry_red;
    logic signed [ENTRY_W-1:0]  entry_green;
    logic signed [ENTRY_W-1:0]  entry_blue;
    logic [PIX_W-1:0]           pixel_red;
    logic [PIX_W-1:0]           pixel_green;
    logic [PIX_W-1:0]           pixel_blue;

    modport source (output valid, kind, entry_index, entry_red, entry_green, entry_blue,
                    pixel_red, pixel_green, pixel_blue, input ready);
    modport sink   (input valid, kind, entry_index, entry_red, entry_green, entry_blue,
                    pixel_red, pixel_green, pixel_blue, output ready);
endinterface

// ===== design/lut3d_out_if.sv =====
interface lut3d_out_if;
    import lut3d_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== design/lut3d_trilinear_color_map.sv =====
// 3d lut color mapper with trilinear interpolation
// in_ch carries one item per handshake: kind 0 writes one lattice entry
// (signed rgb, 12 fraction bits) at entry_index, kind 1 maps one rgb888 pixel.
// out_ch returns one mapped pixel per pixel item, none for load items.
// cfg_we/cfg_wdata set the cube size; write it only while the block is idle.
// throughput: one item per clock unless out_ch stalls; the eight corners come
// from eight replicas of the lattice memory, each read once per cycle and all
// written together by a load item.
// pipeline: 13 register stages; out_ch.valid is the valid bit of the last
// stage.
// a pixel sees every load accepted before it.
// reset clears the pipeline and sets the cube size to 33; the lattice memory
// is not cleared and must be loaded before use.
// when out_ch stalls the pipeline holds; the input stage still takes one
// more item if it is empty.
module lut3d_trilinear_color_map #(
    parameter int MAX_CUBE_SIZE = lut3d_pkg::MAX_CUBE_SIZE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [lut3d_pkg::CFG_W-1:0]  cfg_wdata,
    lut3d_in_if.sink                     in_ch,
    lut3d_out_if.source                  out_ch
);
    import lut3d_pkg::*;

    localparam int NW    = $clog2(MAX_CUBE_SIZE + 1);
    localparam int DEPTH = MAX_CUBE_SIZE * MAX_CUBE_SIZE * MAX_CUBE_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = PIX_W + NW;
    localparam int LW    = 3 * NW;
    localparam int EW    = 3 * ENTRY_W;
    localparam int PW    = 41;
    localparam int SW    = 44;
    localparam int N_RST = (CUBE_RESET > MAX_CUBE_SIZE) ? MAX_CUBE_SIZE :
                           ((CUBE_RESET < 2) ? 2 : CUBE_RESET);

    // cube size registers
    logic [NW-1:0]   n_reg;
    logic [2*NW-1:0] nn_reg;
    logic [NW-1:0]   n_cfg;

    always_comb
    begin
        if (int'(cfg_wdata) < 2)
            n_cfg = NW'(2);
        else if (int'(cfg_wdata) > MAX_CUBE_SIZE)
            n_cfg = NW'(MAX_CUBE_SIZE);
        else
            n_cfg = NW'(cfg_wdata);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg  <= NW'(N_RST);
            nn_reg <= (2*NW)'(N_RST * N_RST);
        end
        else if (cfg_we)
        begin
            n_reg  <= n_cfg;
            nn_reg <= (2*NW)'(n_cfg) * (2*NW)'(n_cfg);
        end
    end

    // pipeline control
    logic [13:1] pvld_reg;
    logic [5:1]  lvld_reg;
    logic        en;
    logic        in_take;

    assign en      = !pvld_reg[13] || out_ch.ready;
    assign in_take = en || !(pvld_reg[1] || lvld_reg[1]);
    assign in_ch.ready = in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg <= '0;
            lvld_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                pvld_reg[1] <= in_ch.valid && (in_ch.kind == KIND_PIXEL);
                lvld_reg[1] <= in_ch.valid && (in_ch.kind == KIND_LOAD);
            end
            if (en)
            begin
                pvld_reg[13:2] <= pvld_reg[12:1];
                lvld_reg[5:2]  <= lvld_reg[4:1];
            end
        end
    end

    // load payload through stage 5
    logic [IDX_W-1:0] idx_reg  [1:5];
    logic [EW-1:0]    data_reg [1:5];

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            idx_reg[1]  <= in_ch.entry_index;
            data_reg[1] <= {in_ch.entry_blue, in_ch.entry_green, in_ch.entry_red};
        end
        if (en)
        begin
            for (int s = 2; s <= 5; s++)
            begin
                idx_reg[s]  <= idx_reg[s-1];
                data_reg[s] <= data_reg[s-1];
            end
        end
    end

    // stage 1: pixel channels
    logic [PIX_W-1:0] pix_s1_reg [3];

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pix_s1_reg[0] <= in_ch.pixel_red;
            pix_s1_reg[1] <= in_ch.pixel_green;
            pix_s1_reg[2] <= in_ch.pixel_blue;
        end
    end

    // stages 2 to 4: scaled position, lattice base and weight per channel
    logic [TW-1:0]    t_s2_reg  [3];
    logic [TW-1:0]    t_s3_reg  [3];
    logic [NW-1:0]    q0_s3_reg [3];
    logic [NW-1:0]    base_s4_reg [3];
    logic [PIX_W-1:0] w_s4_reg  [3];
    logic [TW+8:0]    qprod     [3];
    logic [8:0]       rem0      [3];
    logic [NW-1:0]    q1        [3];
    logic [NW-1:0]    qb        [3];
    logic [PIX_W-1:0] wv        [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            qprod[c] = (TW+9)'(t_s2_reg[c]) * (TW+9)'(RECIP_255);
            rem0[c]  = 9'(t_s3_reg[c] - TW'(q0_s3_reg[c]) * TW'(W_MAX));
            q1[c]    = (rem0[c] >= 9'(W_MAX)) ? q0_s3_reg[c] + NW'(1) : q0_s3_reg[c];
            qb[c]    = (q1[c] > n_reg - NW'(2)) ? n_reg - NW'(2) : q1[c];
            wv[c]    = PIX_W'(t_s3_reg[c] - TW'(qb[c]) * TW'(W_MAX));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                t_s2_reg[c]    <= TW'(pix_s1_reg[c]) * TW'(n_reg - NW'(1));
                t_s3_reg[c]    <= t_s2_reg[c];
                q0_s3_reg[c]   <= qprod[c][16 +: NW];
                base_s4_reg[c] <= qb[c];
                w_s4_reg[c]    <= wv[c];
            end
        end
    end

    // stage 5: linear base index and red-green weight products
    logic [AW-1:0]    lin_s5_reg;
    logic [15:0]      pw_s5_reg [4];
    logic [PIX_W-1:0] wb_s5_reg;
    logic [LW-1:0]    lin_full;
    logic [PIX_W-1:0] wsel_r [2];
    logic [PIX_W-1:0] wsel_g [2];

    always_comb
    begin
        lin_full = LW'(base_s4_reg[2]) * LW'(nn_reg) + LW'(base_s4_reg[1]) * LW'(n_reg)
                 + LW'(base_s4_reg[0]);
        wsel_r[0] = PIX_W'(W_MAX) - w_s4_reg[0];
        wsel_r[1] = w_s4_reg[0];
        wsel_g[0] = PIX_W'(W_MAX) - w_s4_reg[1];
        wsel_g[1] = w_s4_reg[1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_s5_reg <= AW'(lin_full);
            wb_s5_reg  <= w_s4_reg[2];
            for (int k = 0; k < 4; k++)
                pw_s5_reg[k] <= 16'(wsel_r[k & 1]) * 16'(wsel_g[(k >> 1) & 1]);
        end
    end

    // stage 6: corner reads from the eight lattice replicas, full weights
    logic [EW-1:0] rd_s6_reg [8];
    logic [23:0]   wt_s6_reg [8];
    logic [AW-1:0] raddr     [8];
    logic          wr_ok;

    assign wr_ok = lvld_reg[5] && (32'(idx_reg[5]) < 32'(DEPTH));

    always_comb
    begin
        for (int k = 0; k < 8; k++)
            raddr[k] = lin_s5_reg + AW'(k & 1)
                     + ((((k >> 1) & 1) != 0) ? AW'(n_reg) : AW'(0))
                     + ((((k >> 2) & 1) != 0) ? AW'(nn_reg) : AW'(0));
    end

    for (genvar k = 0; k < 8; k++)
    begin : g_bank
        logic [EW-1:0] mem_bank [DEPTH];

        always_ff @(posedge clk)
        begin
            if (en && wr_ok)
                mem_bank[AW'(idx_reg[5])] <= data_reg[5];
            if (en)
                rd_s6_reg[k] <= mem_bank[raddr[k]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 8; k++)
                wt_s6_reg[k] <= 24'(pw_s5_reg[k & 3])
                              * 24'((k >= 4) ? wb_s5_reg : PIX_W'(W_MAX) - wb_s5_reg);
        end
    end

    // stage 7: weighted corner values
    logic signed [PW-1:0] prod_s7_reg [8][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 8; k++)
                for (int c = 0; c < 3; c++)
                    prod_s7_reg[k][c] <= PW'($signed({1'b0, wt_s6_reg[k]})
                                       * $signed(rd_s6_reg[k][ENTRY_W*c +: ENTRY_W]));
        end
    end

    // stages 8 to 10: adder tree over the corners
    logic signed [SW-1:0] sum4_s8_reg  [4][3];
    logic signed [SW-1:0] sum2_s9_reg  [2][3];
    logic signed [SW-1:0] sum_s10_reg  [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int j = 0; j < 4; j++)
                    sum4_s8_reg[j][c] <= SW'(prod_s7_reg[2*j][c]) + SW'(prod_s7_reg[2*j+1][c]);
                for (int j = 0; j < 2; j++)
                    sum2_s9_reg[j][c] <= sum4_s8_reg[2*j][c] + sum4_s8_reg[2*j+1][c];
                sum_s10_reg[c] <= sum2_s9_reg[0][c] + sum2_s9_reg[1][c];
            end
        end
    end

    // stages 11 to 13: round to nearest, clamp to 0..255
    logic signed [SW-1:0] x_s11_reg  [3];
    logic                 neg_s12_reg [3];
    logic                 big_s12_reg [3];
    logic [23:0]          y_s12_reg  [3];
    logic [8:0]           q0_s12_reg [3];
    logic [PIX_W-1:0]     out_s13_reg [3];
    logic [40:0]          yprod [3];
    logic [23:0]          yrem  [3];
    logic [8:0]           yq    [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            yprod[c] = 41'(x_s11_reg[c][35:12]) * 41'(RECIP_FULL);
            yrem[c]  = y_s12_reg[c] - 24'(q0_s12_reg[c]) * 24'(W_FULL);
            yq[c]    = (yrem[c] >= 24'(W_FULL)) ? q0_s12_reg[c] + 9'd1 : q0_s12_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                x_s11_reg[c]   <= sum_s10_reg[c] + SW'(DEN_HALF);
                neg_s12_reg[c] <= x_s11_reg[c] < 0;
                big_s12_reg[c] <= x_s11_reg[c] >= SW'(DEN_TOP);
                y_s12_reg[c]   <= x_s11_reg[c][35:12];
                q0_s12_reg[c]  <= yprod[c][40:32];
                if (neg_s12_reg[c])
                    out_s13_reg[c] <= '0;
                else if (big_s12_reg[c])
                    out_s13_reg[c] <= PIX_W'(W_MAX);
                else
                    out_s13_reg[c] <= yq[c][PIX_W-1:0];
            end
        end
    end

    // output channel
    assign out_ch.valid     = pvld_reg[13];
    assign out_ch.out_red   = out_s13_reg[0];
    assign out_ch.out_green = out_s13_reg[1];
    assign out_ch.out_blue  = out_s13_reg[2];

endmodule

// ===== design/lut3d_chk.sv =====
`include "lut3d_trilinear_color_map_defines.svh"

module lut3d_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue
);
    // stalled result stays offered
    `LUT3D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // stalled result keeps its value
    `LUT3D_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(out_red) && $stable(out_green) && $stable(out_blue))
    // input is refused only behind a stalled result
    `LUT3D_ASSERT_NOW(a_in_backpressure, !in_ready, out_valid && !out_ready)
    // a refused item with a full input stage stays refused while out_ready stays low
    `LUT3D_ASSERT_NEXT(a_stall_chain, !in_ready && in_valid && !out_ready, !in_ready || out_ready)
endmodule

bind lut3d_trilinear_color_map lut3d_chk u_lut3d_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_red   (out_ch.out_red),
    .out_green (out_ch.out_green),
    .out_blue  (out_ch.out_blue)
);

// ===== dv/tb_lut3d_trilinear_color_map.sv =====
module tb_lut3d_trilinear_color_map;
    timeunit 1ns;
    timeprecision 1ps;
    import lut3d_pkg::*;

    localparam int STORE_DEPTH = 33 * 33 * 33;
    localparam int LATENCY     = 13;

    typedef struct packed {
        logic        kind;
        logic [15:0] idx;
        logic [15:0] er;
        logic [15:0] eg;
        logic [15:0] eb;
        logic [7:0]  pr;
        logic [7:0]  pg;
        logic [7:0]  pb;
    } item_t;

    localparam int IW = $bits(item_t);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    // directed row: optional config write before the item, optional typed expectation
    typedef struct {
        bit         set_size;
        logic [5:0] size_val;
        item_t      itm;
        bit         has_known;
        pixel_t     known;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    lut3d_in_if  in_ch();
    lut3d_out_if out_ch();

    lut3d_trilinear_color_map dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #10 clk = ~clk;

    // predictor state
    logic signed [15:0] lattice [0:STORE_DEPTH-1][0:2];
    logic [5:0] size_reg;
    pixel_t mapped_q[$];
    int errors = 0;
    int pixels_sent = 0;
    int loads_sent = 0;
    int pixels_seen = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int sizes_used[$];

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [7:0] round_clamp(input longint sum);
        longint den, num, q;
        den = 64'd266342400;
        num = 2 * sum + den;
        q = num / (2 * den);
        if ((num % (2 * den)) != 0 && num < 0)
            q = q - 1;
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    function automatic int eff_size();
        int n;
        n = size_reg;
        if (n < 2) n = 2;
        if (n > 33) n = 33;
        return n;
    endfunction

    // trilinear map of one pixel against the predictor's lattice
    function automatic pixel_t interpolate(input item_t it);
        int n, t, b;
        int base[3], wn[3], p[3];
        longint acc[3], wt;
        int dr, dg, db, ix;
        pixel_t res;
        n = eff_size();
        p[0] = it.pr; p[1] = it.pg; p[2] = it.pb;
        for (int c = 0; c < 3; c++)
        begin
            t = p[c] * (n - 1);
            b = t / 255;
            if (b > n - 2) b = n - 2;
            base[c] = b;
            wn[c] = t - 255 * b;
            acc[c] = 0;
        end
        for (int k = 0; k < 8; k++)
        begin
            dr = k & 1; dg = (k >> 1) & 1; db = (k >> 2) & 1;
            wt = longint'(dr ? wn[0] : 255 - wn[0]) * longint'(dg ? wn[1] : 255 - wn[1])
                 * longint'(db ? wn[2] : 255 - wn[2]);
            ix = (base[2] + db) * n * n + (base[1] + dg) * n + (base[0] + dr);
            for (int c = 0; c < 3; c++)
                acc[c] += wt * longint'(lattice[ix][c]);
        end
        res.r = round_clamp(acc[0]);
        res.g = round_clamp(acc[1]);
        res.b = round_clamp(acc[2]);
        return res;
    endfunction

    // apply one accepted item to the predictor
    task automatic predict(input item_t it);
        if (it.kind == KIND_LOAD)
        begin
            loads_sent++;
            if (it.idx < STORE_DEPTH)
            begin
                lattice[it.idx][0] = it.er;
                lattice[it.idx][1] = it.eg;
                lattice[it.idx][2] = it.eb;
            end
        end
        else
        begin
            pixels_sent++;
            mapped_q = {mapped_q, interpolate(it)};
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            pixels_seen++;
            if (mapped_q.size() == 0)
            begin
                $display("unexpected pixel result at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = mapped_q.pop_front();
                if (out_ch.out_red !== want.r) report("out_red", out_ch.out_red, want.r);
                if (out_ch.out_green !== want.g) report("out_green", out_ch.out_green, want.g);
                if (out_ch.out_blue !== want.b) report("out_blue", out_ch.out_blue, want.b);
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle);

    // send one item, idling randomly before it
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= it.kind;
        in_ch.entry_index <= it.idx;
        in_ch.entry_red   <= it.er;
        in_ch.entry_green <= it.eg;
        in_ch.entry_blue  <= it.eb;
        in_ch.pixel_red   <= it.pr;
        in_ch.pixel_green <= it.pg;
        in_ch.pixel_blue  <= it.pb;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict(it);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (mapped_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_size(input logic [5:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        size_reg   = v;
        sizes_used = {sizes_used, int'(v)};
    endtask

    function automatic item_t load_item(input int ix, input logic [15:0] r,
                                        input logic [15:0] g, input logic [15:0] b);
        item_t it;
        it.kind = KIND_LOAD;
        it.idx = 16'(ix);
        it.er = r; it.eg = g; it.eb = b;
        it.pr = 8'($urandom); it.pg = 8'($urandom); it.pb = 8'($urandom);
        return it;
    endfunction

    function automatic item_t pixel_item(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        item_t it;
        it = item_t'(IW'({$urandom, $urandom, $urandom}));
        it.kind = KIND_PIXEL;
        it.pr = r; it.pg = g; it.pb = b;
        return it;
    endfunction

    // entry value: mode 0 ramps with the lattice coordinate, mode 1 is random with extremes
    function automatic logic [15:0] entry_val(input int mode, input int coord, input int n);
        int v;
        if (mode == 0)
            return 16'((coord * 32767) / (n - 1));
        v = ($urandom_range(2) == 0) ? 32767 : -32768;
        if ($urandom_range(3) == 0)
            return 16'(v);
        return 16'($urandom);
    endfunction

    // fill the whole lattice of the current size; mode picks the content
    task automatic fill_lattice(input int mode);
        int n;
        n = eff_size();
        for (int b = 0; b < n; b++)
            for (int g = 0; g < n; g++)
                for (int r = 0; r < n; r++)
                    send_item(load_item(b * n * n + g * n + r, entry_val(mode, r, n),
                                        entry_val(mode, g, n), entry_val(mode, b, n)));
    endtask

    // load the eight corners around one pixel, then send the pixel
    task automatic send_mapped(input item_t px, input int mode);
        int n, t, b, cr, cg, cb;
        int base[3], p[3];
        n = eff_size();
        p[0] = px.pr; p[1] = px.pg; p[2] = px.pb;
        for (int c = 0; c < 3; c++)
        begin
            t = p[c] * (n - 1);
            b = t / 255;
            if (b > n - 2) b = n - 2;
            base[c] = b;
        end
        for (int k = 0; k < 8; k++)
        begin
            cr = base[0] + (k & 1);
            cg = base[1] + ((k >> 1) & 1);
            cb = base[2] + ((k >> 2) & 1);
            send_item(load_item(cb * n * n + cg * n + cr, entry_val(mode, cr, n),
                                entry_val(mode, cg, n), entry_val(mode, cb, n)));
        end
        send_item(px);
    endtask

    // random phase for one cube size; large lattices are loaded corner by corner
    task automatic random_phase(input logic [5:0] sz, input int count);
        int n, ix, pick;
        bit sparse;
        item_t px;
        drain();
        set_size(sz);
        n = eff_size();
        sparse = (n * n * n > 200);
        if (!sparse)
            fill_lattice(1);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
            begin
                // rewrite a live entry
                ix = $urandom_range(n * n * n - 1);
                send_item(load_item(ix, 16'($urandom), 16'($urandom), 16'($urandom)));
            end
            else if (pick == 1)
            begin
                // loads past the store are ignored
                send_item(load_item(int'($urandom_range(65535, STORE_DEPTH)), 16'($urandom),
                                    16'($urandom), 16'($urandom)));
            end
            else
            begin
                if (pick == 2)
                    px = pixel_item(8'($urandom_range(1) * 255), 8'($urandom_range(1) * 255),
                                    8'($urandom));
                else
                    px = pixel_item(8'($urandom), 8'($urandom), 8'($urandom));
                if (sparse)
                    send_mapped(px, 1);
                else
                    send_item(px);
            end
        end
    endtask

    row_t rows[$];

    initial
    begin
        row_t rw;
        item_t it;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_LOAD;
        in_ch.entry_index = '0;
        in_ch.entry_red = '0;
        in_ch.entry_green = '0;
        in_ch.entry_blue = '0;
        in_ch.pixel_red = '0;
        in_ch.pixel_green = '0;
        in_ch.pixel_blue = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
            for (int c = 0; c < 3; c++)
                lattice[i][c] = '0;
        size_reg = CUBE_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: size 2, a constant lattice and corner saturation
        send_idle = 0;
        recv_idle = 0;
        set_size(6'd2);
        for (int i = 0; i < 8; i++)
        begin
            rw = '{default: '0};
            rw.itm = load_item(i, 16'sh7fff, 16'sh8000, 16'h0800);
            rows = {rows, rw};
        end
        // max positive clamps to 255, most negative to 0, half rounds up to 128
        rw = '{default: '0};
        rw.itm = pixel_item(8'd0, 8'd0, 8'd0);
        rw.has_known = 1'b1; rw.known = '{8'd255, 8'd0, 8'd128};
        rows = {rows, rw};
        rw.itm = pixel_item(8'd255, 8'd255, 8'd255);
        rows = {rows, rw};
        rw.itm = pixel_item(8'd128, 8'd7, 8'd255);
        rows = {rows, rw};
        // ignored load past the store, then a checked pixel
        rw = '{default: '0};
        rw.itm = load_item(16'hffff, 16'h0, 16'h0, 16'h0);
        rows = {rows, rw};
        rw.itm = load_item(STORE_DEPTH, 16'h0, 16'h0, 16'h0);
        rows = {rows, rw};
        rw.itm = pixel_item(8'd1, 8'd254, 8'd100);
        rows = {rows, rw};
        // one corner changed: predictor handles the interpolation
        rw.itm = load_item(7, 16'h0, 16'h7fff, 16'h4000);
        rows = {rows, rw};
        rw.itm = pixel_item(8'd200, 8'd200, 8'd200);
        rows = {rows, rw};
        // size 0 and 1 saturate to 2, same lattice
        rw = '{default: '0};
        rw.set_size = 1'b1; rw.size_val = 6'd0;
        rw.itm = pixel_item(8'd255, 8'd255, 8'd255);
        rows = {rows, rw};
        rw.size_val = 6'd1;
        rw.itm = pixel_item(8'd0, 8'd128, 8'd255);
        rows = {rows, rw};
        foreach (rows[i])
        begin
            if (rows[i].set_size)
            begin
                drain();
                set_size(rows[i].size_val);
            end
            send_item(rows[i].itm);
            // typed expectation must agree with the predictor
            if (rows[i].has_known && mapped_q.size() != 0 &&
                mapped_q[$] !== rows[i].known)
                report("directed row", mapped_q[$], rows[i].known);
        end

        // ramp lattice corners at full size, red and green channels at extremes
        drain();
        set_size(6'd33);
        it = pixel_item(8'd255, 8'd0, 8'd128);
        send_mapped(it, 0);
        send_mapped(pixel_item(8'd0, 8'd255, 8'd1), 0);

        // random phases: receiver-heavy idling, sender-heavy, none
        send_idle = 37; recv_idle = 85;
        random_phase(6'd3, 250);
        send_idle = 85; recv_idle = 37;
        random_phase(6'd63, 55);
        drain();
        send_idle = 0; recv_idle = 0;
        random_phase(6'd5, 200);
        random_phase(6'd2, 150);
        random_phase(6'd17, 30);

        drain();
        $display("covered %0d pixels and %0d loads over %0d cube size settings",
                 pixels_sent, loads_sent, sizes_used.size());
        $display("results checked: %0d, mismatches: %0d", pixels_seen, errors);
        if (errors == 0 && mapped_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
